// ----- hdl/tlss_pkg.sv -----
package tlss_pkg;

    localparam int MaxSteps      = 24;
    localparam int DefSteps      = 16;
    localparam int HalfTurnQ7    = 23040;
    localparam int FullTurnQ7    = 46080;
    localparam int QuarterQ16    = 5898240;
    localparam int HalfQ16       = 11796480;
    localparam int InvGainQ30    = 652032874;
    localparam logic [15:0] TurnRateRst = 16'd11520;
    localparam logic [15:0] ArrRadRst   = 16'd1280;

    // vector cordic data path widths
    localparam int VW = 44;
    // rotation cordic x/y width, and the angle width shared by both chains
    localparam int RW = 33;
    localparam int ZW = 26;

    localparam logic [0:0] RegTurnRate = 1'b0;
    localparam logic [0:0] RegArrRad   = 1'b1;

    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        logic signed [ZW-1:0] v;
        begin
            case (i)
                0: v = 26'sd2949120;   1: v = 26'sd1740967;  2: v = 26'sd919879;
                3: v = 26'sd466945;    4: v = 26'sd234378;   5: v = 26'sd117304;
                6: v = 26'sd58666;     7: v = 26'sd29335;    8: v = 26'sd14668;
                9: v = 26'sd7334;      10: v = 26'sd3667;    11: v = 26'sd1833;
                12: v = 26'sd917;      13: v = 26'sd458;     14: v = 26'sd229;
                15: v = 26'sd115;      16: v = 26'sd57;      17: v = 26'sd29;
                18: v = 26'sd14;       19: v = 26'sd7;       20: v = 26'sd4;
                21: v = 26'sd2;        22: v = 26'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // item context carried beside the cordic cells
    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] gx;
        logic signed [23:0] gy;
        logic signed [15:0] head;
        logic [19:0]        speed;
        logic [15:0]        dt;
        logic               arr;
        logic               zero;
    } t_ctx;

endpackage

// ----- hdl/tlss_vec_cell.sv -----
module tlss_vec_cell
    import tlss_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [VW-1:0] i_x,
    input  logic signed [VW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    input  t_ctx                 i_ctx,
    output logic signed [VW-1:0] o_x,
    output logic signed [VW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output t_ctx                 o_ctx
);
    logic signed [VW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    t_ctx r_ctx;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_y[VW-1]) begin
                r_x <= i_x + (i_y >>> STEP);
                r_y <= i_y - (i_x >>> STEP);
                r_z <= i_z + atan_q16(STEP);
            end else begin
                r_x <= i_x - (i_y >>> STEP);
                r_y <= i_y + (i_x >>> STEP);
                r_z <= i_z - atan_q16(STEP);
            end
            r_ctx <= i_ctx;
        end
    end
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
    assign o_ctx = r_ctx;
endmodule

// ----- hdl/tlss_rot_cell.sv -----
module tlss_rot_cell
    import tlss_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [RW-1:0] i_x,
    input  logic signed [RW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    input  t_ctx                 i_ctx,
    output logic signed [RW-1:0] o_x,
    output logic signed [RW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output t_ctx                 o_ctx
);
    logic signed [RW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    t_ctx r_ctx;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_z[ZW-1]) begin
                r_x <= i_x - (i_y >>> STEP);
                r_y <= i_y + (i_x >>> STEP);
                r_z <= i_z - atan_q16(STEP);
            end else begin
                r_x <= i_x + (i_y >>> STEP);
                r_y <= i_y - (i_x >>> STEP);
                r_z <= i_z + atan_q16(STEP);
            end
            r_ctx <= i_ctx;
        end
    end
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
    assign o_ctx = r_ctx;
endmodule

// ----- hdl/turn_limited_seek_step_unit.sv -----
// channel   | dir | width | content
// s_axis    | in  | 152   | item: positions, goal, heading, speed, frame time
// m_axis    | out | 128   | result: new position, heading, velocity, arrived
// apb       | in  | 16    | turn_rate at 0, arrival_radius at 4
// one item per cycle while the output is not stalled; stages a-c, vector cells, d, e,
// rotation cells, f, g; the whole pipe advances together, set by the output register
// a stalled output freezes every cell; s_axis_tready follows m_axis_tready
// or an empty output register, and is low during reset
// synchronous active-low reset clears valid bits and loads the apb register defaults
module turn_limited_seek_step_unit
    import tlss_pkg::*;
#(
    parameter int CORDIC_STEPS = DefSteps
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x[23:0] pos_y[47:24] goal_x[71:48] goal_y[95:72] heading[111:96]
    // top_speed[131:112] frame_time[147:132] zeros[151:148]
    input  logic [151:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // new_pos_x[23:0] new_pos_y[47:24] new_heading[63:48] vel_x[84:64]
    // vel_y[105:85] arrived[106] zeros[127:107]
    output logic [127:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int N = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;
    // front 3 + vector N + 2 mid + rotation N + 2 back
    localparam int NV = 2*N + 7;

    logic [15:0] r_turn_rate, r_arr_rad;
    logic en;
    logic [NV-1:0] r_vld;

    assign pready = 1'b1;
    assign prdata = {16'd0, (paddr[2] ? r_arr_rad : r_turn_rate)};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_rate <= TurnRateRst;
            r_arr_rad   <= ArrRadRst;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == RegArrRad) r_arr_rad <= pwdata[15:0];
            else r_turn_rate <= pwdata[15:0];
        end
    end

    // all stages move when the output can take data
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en && i_rst_n;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en) r_vld <= {r_vld[NV-2:0], s_axis_tvalid};
    end
    assign m_axis_tvalid = r_vld[NV-1];

    // stage a: capture and deltas
    t_ctx a_ctx, r_ctx_a;
    logic signed [24:0] r_dx, r_dy;
    assign a_ctx.px    = s_axis_tdata[23:0];
    assign a_ctx.py    = s_axis_tdata[47:24];
    assign a_ctx.gx    = s_axis_tdata[71:48];
    assign a_ctx.gy    = s_axis_tdata[95:72];
    assign a_ctx.head  = s_axis_tdata[111:96];
    assign a_ctx.speed = s_axis_tdata[131:112];
    assign a_ctx.dt    = s_axis_tdata[147:132];
    assign a_ctx.arr   = 1'b0;
    assign a_ctx.zero  = 1'b0;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctx_a <= a_ctx;
            r_dx <= 25'(signed'(a_ctx.gx)) - 25'(signed'(a_ctx.px));
            r_dy <= 25'(signed'(a_ctx.gy)) - 25'(signed'(a_ctx.py));
        end
    end

    // stage b: squares of deltas and of the arrival radius
    t_ctx r_ctx_b;
    logic [49:0] r_dx2, r_dy2;
    logic signed [24:0] r_dxb, r_dyb;
    logic [31:0] r_r2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctx_b <= r_ctx_a;
            r_dx2 <= 50'(r_dx) * 50'(r_dx);
            r_dy2 <= 50'(r_dy) * 50'(r_dy);
            r_dxb <= r_dx;
            r_dyb <= r_dy;
            r_r2 <= r_arr_rad * r_arr_rad;
        end
    end

    // stage c: distance test and quadrant pre-rotation
    t_ctx c_ctx;
    logic signed [VW-1:0] c_x, c_y, r_vx0, r_vy0;
    logic signed [ZW-1:0] c_z, r_vz0;
    t_ctx r_ctx_c;
    always_comb begin
        logic signed [VW-1:0] xs, ys;
        xs = VW'(signed'(r_dxb)) <<< 16;
        ys = VW'(signed'(r_dyb)) <<< 16;
        c_ctx = r_ctx_b;
        c_ctx.arr  = ({1'b0, r_dx2} + {1'b0, r_dy2}) < {19'd0, r_r2};
        c_ctx.zero = (r_dxb == '0) && (r_dyb == '0);
        c_x = xs; c_y = ys; c_z = '0;
        if (xs[VW-1]) begin
            if (!ys[VW-1]) begin
                c_x = ys; c_y = -xs; c_z = ZW'(QuarterQ16);
            end else begin
                c_x = -ys; c_y = xs; c_z = -ZW'(QuarterQ16);
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctx_c <= c_ctx;
            r_vx0 <= c_x; r_vy0 <= c_y; r_vz0 <= c_z;
        end
    end

    // vector cordic chain
    logic signed [VW-1:0] vx [0:N];
    logic signed [VW-1:0] vy [0:N];
    logic signed [ZW-1:0] vz [0:N];
    t_ctx vc [0:N];
    assign vx[0] = r_vx0; assign vy[0] = r_vy0; assign vz[0] = r_vz0;
    assign vc[0] = r_ctx_c;
    for (genvar g = 0; g < N; g++) begin : g_vec
        tlss_vec_cell #(.STEP(g)) u_cell (
            .i_clk(i_clk), .i_en(en),
            .i_x(vx[g]), .i_y(vy[g]), .i_z(vz[g]), .i_ctx(vc[g]),
            .o_x(vx[g+1]), .o_y(vy[g+1]), .o_z(vz[g+1]), .o_ctx(vc[g+1])
        );
    end

    // stage d: bearing, heading error, turn step
    t_ctx r_ctx_d;
    logic signed [17:0] r_bear, r_diff;
    logic [16:0] r_step;
    always_ff @(posedge i_clk) begin
        logic signed [ZW-1:0] zr;
        logic signed [17:0] b, d;
        logic [31:0] prod;
        if (en) begin
            zr = (vz[N] + ZW'(256)) >>> 9;
            b = 18'(zr);
            if (b > 18'sd23040) b = b - 18'sd46080;
            if (b < -18'sd23040) b = b + 18'sd46080;
            if (vc[N].zero) b = '0;
            d = b - 18'(vc[N].head);
            if (d > 18'sd23040) d = d - 18'sd46080;
            if (d < -18'sd23040) d = d + 18'sd46080;
            if (d > 18'sd23040) d = d - 18'sd46080;
            if (d < -18'sd23040) d = d + 18'sd46080;
            prod = r_turn_rate * vc[N].dt;
            r_step <= 17'((33'(prod) + 33'd32768) >> 16);
            r_bear <= b;
            r_diff <= d;
            r_ctx_d <= vc[N];
        end
    end

    // stage e: new heading and rotation pre-fold
    t_ctx r_ctx_e;
    logic signed [RW-1:0] r_rx0, r_ry0;
    logic signed [ZW-1:0] r_rz0;
    logic signed [15:0] r_newh;
    logic r_flip0;
    always_ff @(posedge i_clk) begin
        logic signed [18:0] ad, h;
        logic signed [ZW-1:0] z;
        logic f;
        if (en) begin
            ad = r_diff[17] ? -19'(r_diff) : 19'(r_diff);
            if (ad < 19'(signed'({1'b0, r_step})))
                h = 19'(r_bear);
            else if (r_diff > 0)
                h = 19'(r_ctx_d.head) + 19'(signed'({1'b0, r_step}));
            else
                h = 19'(r_ctx_d.head) - 19'(signed'({1'b0, r_step}));
            if (h > 19'sd23040) h = h - 19'sd46080;
            if (h < -19'sd23040) h = h + 19'sd46080;
            if (h > 19'sd23040) h = h - 19'sd46080;
            if (h < -19'sd23040) h = h + 19'sd46080;
            z = ZW'(h) <<< 9;
            f = 1'b0;
            if (z > ZW'(QuarterQ16)) begin
                z = z - ZW'(HalfQ16); f = 1'b1;
            end else if (z < -ZW'(QuarterQ16)) begin
                z = z + ZW'(HalfQ16); f = 1'b1;
            end
            r_flip0 <= f;
            r_rz0 <= z;
            r_rx0 <= RW'(InvGainQ30);
            r_ry0 <= '0;
            r_newh <= 16'(h);
            r_ctx_e <= r_ctx_d;
        end
    end

    // fold flip and new heading into context fields for the rotation chain
    t_ctx e_ctx;
    always_comb begin
        e_ctx = r_ctx_e;
        e_ctx.head = r_newh;
        e_ctx.zero = r_flip0;
    end

    logic signed [RW-1:0] rx [0:N];
    logic signed [RW-1:0] ry [0:N];
    logic signed [ZW-1:0] rz [0:N];
    t_ctx rc [0:N];
    assign rx[0] = r_rx0; assign ry[0] = r_ry0; assign rz[0] = r_rz0;
    assign rc[0] = e_ctx;
    for (genvar g = 0; g < N; g++) begin : g_rot
        tlss_rot_cell #(.STEP(g)) u_cell (
            .i_clk(i_clk), .i_en(en),
            .i_x(rx[g]), .i_y(ry[g]), .i_z(rz[g]), .i_ctx(rc[g]),
            .o_x(rx[g+1]), .o_y(ry[g+1]), .o_z(rz[g+1]), .o_ctx(rc[g+1])
        );
    end
    logic unused_z;
    assign unused_z = ^rz[N];

    // stage f: velocity
    t_ctx r_ctx_f;
    logic signed [20:0] r_velx, r_vely;
    function automatic logic signed [20:0] vel_sat(input logic signed [RW-1:0] t,
                                                   input logic [19:0] sp);
        logic signed [54:0] p;
        logic signed [24:0] q;
        begin
            p = 55'(signed'({1'b0, sp})) * 55'(t) + (55'sd1 <<< 29);
            q = 25'(p >>> 30);
            if (q > 25'sd1048575) return 21'sd1048575;
            if (q < -25'sd1048576) return -21'sd1048576;
            return 21'(q);
        end
    endfunction
    always_ff @(posedge i_clk) begin
        logic signed [RW-1:0] c, s;
        if (en) begin
            c = rc[N].zero ? -rx[N] : rx[N];
            s = rc[N].zero ? -ry[N] : ry[N];
            r_velx <= rc[N].arr ? '0 : vel_sat(c, rc[N].speed);
            r_vely <= rc[N].arr ? '0 : vel_sat(s, rc[N].speed);
            r_ctx_f <= rc[N];
        end
    end

    // stage g: position update and output register
    logic [127:0] r_out;
    function automatic logic signed [23:0] pos_upd(input logic signed [23:0] p,
                                                   input logic signed [20:0] v,
                                                   input logic [15:0] dt);
        logic signed [38:0] m;
        logic signed [25:0] s;
        begin
            m = 39'(v) * 39'(signed'({1'b0, dt})) + 39'sd32768;
            s = 26'(p) + 26'(m >>> 16);
            if (s > 26'sd8388607) return 24'sh7FFFFF;
            if (s < -26'sd8388608) return 24'sh800000;
            return 24'(s);
        end
    endfunction
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out[23:0]   <= r_ctx_f.arr ? r_ctx_f.gx : pos_upd(r_ctx_f.px, r_velx, r_ctx_f.dt);
            r_out[47:24]  <= r_ctx_f.arr ? r_ctx_f.gy : pos_upd(r_ctx_f.py, r_vely, r_ctx_f.dt);
            r_out[63:48]  <= r_ctx_f.head;
            r_out[84:64]  <= r_velx;
            r_out[105:85] <= r_vely;
            r_out[106]    <= r_ctx_f.arr;
            r_out[127:107] <= '0;
        end
    end
    assign m_axis_tdata = r_out;

    // an arrived result never carries a velocity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[106] |-> m_axis_tdata[105:64] == '0)
        else $error("arrived result with nonzero velocity");
    // stall freezes the output
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    // heading stays in range
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[63:48]) <= 16'sd23040 &&
                           $signed(m_axis_tdata[63:48]) >= -16'sd23040))
        else $error("heading out of range");
endmodule
